>>> design/sobel_edge_magnitude_macros.svh
// Assertion macros used by the Sobel edge magnitude top level.
`ifndef SOBEL_EDGE_MAGNITUDE_MACROS_SVH
`define SOBEL_EDGE_MAGNITUDE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SOBEL_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define SOBEL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/sobel_pkg.sv
// Shared constants and control types for the Sobel edge magnitude block.
`default_nettype none

package sobel_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 16;
    localparam int PIX_W      = 8;
    localparam int GRAD_W     = 11;
    localparam int ABS_W      = 10;
    localparam int SQ_W       = 2 * ABS_W;
    localparam int SUM_W      = SQ_W + 1;
    localparam int RAD_W      = 2 * PIX_W;
    localparam int REM_W      = PIX_W + 3;
    localparam int STEP_W     = $clog2(PIX_W);
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int OUT_DATA_W = 32;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(640);
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(480);
    localparam logic [WIDTH_W-1:0]  WIDTH_MIN    = WIDTH_W'(3);
    localparam logic [HEIGHT_W-1:0] HEIGHT_MIN   = HEIGHT_W'(3);

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 1'b1;

    typedef struct packed {
        logic accept;
        logic grad;
        logic sq_x;
        logic sq_y;
        logic sqrt_step;
        logic out_load;
    } sobel_cmd_t;

    typedef struct packed {
        logic emit;
        logic sqrt_last;
        logic out_free;
    } sobel_status_t;

endpackage

`default_nettype wire

>>> design/sobel_ctrl.sv
// Controller state machine sequencing one pixel request through the datapath.
`default_nettype none

module sobel_ctrl
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire sobel_pkg::sobel_status_t status,
    output sobel_pkg::sobel_cmd_t       cmd
);
    import sobel_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_GRAD = 6'b000010,
        ST_SQX  = 6'b000100,
        ST_SQY  = 6'b001000,
        ST_SQRT = 6'b010000,
        ST_DONE = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_GRAD;
                end
            end
            ST_GRAD:
            begin
                cmd.grad   = 1'b1;
                state_next = status.emit ? ST_SQX : ST_IDLE;
            end
            ST_SQX:
            begin
                cmd.sq_x   = 1'b1;
                state_next = ST_SQY;
            end
            ST_SQY:
            begin
                cmd.sq_y   = 1'b1;
                state_next = ST_SQRT;
            end
            ST_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                if (status.sqrt_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

>>> design/sobel_datapath.sv
// Datapath: line stores, window, gradients, squaring, root and output register.
`default_nettype none

module sobel_datapath
(
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   cfg_we,
    input  wire logic [sobel_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [sobel_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  wire logic [sobel_pkg::PIX_W-1:0]            grey_pixel,
    input  wire logic                                   frame_start,
    input  wire sobel_pkg::sobel_cmd_t                  cmd,
    output sobel_pkg::sobel_status_t                    status,
    input  wire logic                                   m_tready,
    output logic                                        m_tvalid,
    output logic [sobel_pkg::PIX_W-1:0]                 edge_magnitude,
    output logic signed [sobel_pkg::GRAD_W-1:0]         gradient_x,
    output logic signed [sobel_pkg::GRAD_W-1:0]         gradient_y,
    output logic                                        frame_end
);
    import sobel_pkg::*;

    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [WIDTH_W-1:0]  w_eff;
    logic [HEIGHT_W-1:0] h_eff;

    logic [COL_W-1:0]    column_reg;
    logic [COL_W-1:0]    column_next;
    logic [HEIGHT_W-1:0] row_reg;
    logic [HEIGHT_W-1:0] row_next;
    logic [COL_W-1:0]    rd_addr;

    logic [COL_W-1:0]    cur_col_reg;
    logic [HEIGHT_W-1:0] cur_row_reg;
    logic [PIX_W-1:0]    pixel_reg;

    logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
    logic [PIX_W-1:0] middle_mem [MAX_WIDTH];
    logic [PIX_W-1:0] top_reg;
    logic [PIX_W-1:0] mid_reg;

    logic [PIX_W-1:0] win_reg [6];

    logic [ABS_W-1:0]         left_sum;
    logic [ABS_W-1:0]         right_sum;
    logic [ABS_W-1:0]         upper_sum;
    logic [ABS_W-1:0]         lower_sum;
    logic signed [GRAD_W-1:0] gx_next;
    logic signed [GRAD_W-1:0] gy_next;
    logic signed [GRAD_W-1:0] gx_reg;
    logic signed [GRAD_W-1:0] gy_reg;
    logic                     last_reg;
    logic                     last_next;
    logic [WIDTH_W-1:0]       col_ext;
    logic [WIDTH_W-1:0]       col_inc;

    logic signed [GRAD_W-1:0] mul_in;
    logic [GRAD_W-1:0]        mul_neg;
    logic [ABS_W-1:0]         mul_abs;
    logic [SQ_W-1:0]          product;
    logic [SQ_W-1:0]          sq_reg;
    logic [SUM_W-1:0]         sum_next;

    logic [RAD_W-1:0]  rad_reg;
    logic              sat_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [PIX_W-1:0]  root_reg;
    logic [STEP_W-1:0] step_reg;
    logic [REM_W-1:0]  rem_shift;
    logic [REM_W-1:0]  trial;
    logic              trial_ge;

    logic                     out_valid_reg;
    logic [PIX_W-1:0]         out_mag_reg;
    logic signed [GRAD_W-1:0] out_gx_reg;
    logic signed [GRAD_W-1:0] out_gy_reg;
    logic                     out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_IDX_WIDTH:  width_reg  <= cfg_data[WIDTH_W-1:0];
                CFG_IDX_HEIGHT: height_reg <= cfg_data[HEIGHT_W-1:0];
                default:        width_reg  <= width_reg;
            endcase
        end
    end

    always_comb
    begin
        if (width_reg < WIDTH_MIN)
        begin
            w_eff = WIDTH_MIN;
        end
        else if (width_reg > WIDTH_W'(MAX_WIDTH))
        begin
            w_eff = WIDTH_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = width_reg;
        end
        h_eff = (height_reg < HEIGHT_MIN) ? HEIGHT_MIN : height_reg;
    end

    assign rd_addr = frame_start ? '0 : column_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            top_reg <= upper_mem[rd_addr];
            mid_reg <= middle_mem[rd_addr];
        end
        if (cmd.grad)
        begin
            upper_mem[cur_col_reg]  <= mid_reg;
            middle_mem[cur_col_reg] <= pixel_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            pixel_reg   <= grey_pixel;
            cur_col_reg <= rd_addr;
            cur_row_reg <= frame_start ? '0 : row_reg;
        end
    end

    assign col_ext = {1'b0, cur_col_reg};
    assign col_inc = col_ext + WIDTH_W'(1);

    assign status.emit = (cur_col_reg >= COL_W'(2)) && (col_ext < w_eff)
                         && (cur_row_reg >= HEIGHT_W'(2)) && (cur_row_reg < h_eff);

    always_comb
    begin
        last_next   = (cur_row_reg == h_eff - HEIGHT_W'(1))
                      && (col_ext == w_eff - WIDTH_W'(1));
        if (col_inc >= w_eff)
        begin
            column_next = '0;
            row_next    = (cur_row_reg == '1) ? cur_row_reg : cur_row_reg + HEIGHT_W'(1);
        end
        else
        begin
            column_next = col_inc[COL_W-1:0];
            row_next    = cur_row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg <= '0;
            row_reg    <= '0;
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (cmd.grad)
        begin
            column_reg <= column_next;
            row_reg    <= row_next;
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= top_reg;
            win_reg[4] <= mid_reg;
            win_reg[5] <= pixel_reg;
        end
    end

    always_comb
    begin
        left_sum  = {2'b00, win_reg[0]} + {1'b0, win_reg[1], 1'b0} + {2'b00, win_reg[2]};
        right_sum = {2'b00, top_reg} + {1'b0, mid_reg, 1'b0} + {2'b00, pixel_reg};
        upper_sum = {2'b00, win_reg[0]} + {1'b0, win_reg[3], 1'b0} + {2'b00, top_reg};
        lower_sum = {2'b00, win_reg[2]} + {1'b0, win_reg[5], 1'b0} + {2'b00, pixel_reg};
        gx_next   = $signed({1'b0, right_sum}) - $signed({1'b0, left_sum});
        gy_next   = $signed({1'b0, lower_sum}) - $signed({1'b0, upper_sum});
    end

    always_comb
    begin
        mul_in   = cmd.sq_y ? gy_reg : gx_reg;
        mul_neg  = GRAD_W'(-mul_in);
        mul_abs  = mul_in[GRAD_W-1] ? mul_neg[ABS_W-1:0] : mul_in[ABS_W-1:0];
        product  = mul_abs * mul_abs;
        sum_next = {1'b0, sq_reg} + {1'b0, product};
    end

    always_comb
    begin
        rem_shift = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
        trial     = {1'b0, root_reg, 2'b01};
        trial_ge  = (rem_shift >= trial);
    end

    assign status.sqrt_last = (step_reg == '1);

    always_ff @(posedge clk)
    begin
        if (cmd.grad)
        begin
            gx_reg   <= gx_next;
            gy_reg   <= gy_next;
            last_reg <= last_next;
        end
        if (cmd.sq_x)
        begin
            sq_reg <= product;
        end
        if (cmd.sq_y)
        begin
            rad_reg  <= sum_next[RAD_W-1:0];
            sat_reg  <= |sum_next[SUM_W-1:RAD_W];
            rem_reg  <= '0;
            root_reg <= '0;
            step_reg <= '0;
        end
        else if (cmd.sqrt_step)
        begin
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            rem_reg  <= trial_ge ? (rem_shift - trial) : rem_shift;
            root_reg <= {root_reg[PIX_W-2:0], trial_ge};
            step_reg <= step_reg + STEP_W'(1);
        end
    end

    assign status.out_free = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_mag_reg  <= sat_reg ? '1 : root_reg;
            out_gx_reg   <= gx_reg;
            out_gy_reg   <= gy_reg;
            out_last_reg <= last_reg;
        end
    end

    assign m_tvalid       = out_valid_reg;
    assign edge_magnitude = out_mag_reg;
    assign gradient_x     = out_gx_reg;
    assign gradient_y     = out_gy_reg;
    assign frame_end      = out_last_reg;

endmodule

`default_nettype wire

>>> design/sobel_edge_magnitude.sv
// Top level of the Sobel 3x3 gradient magnitude block.
//
// Input stream: one grey pixel per request in raster order, s_tuser marks the
// first pixel of a frame and restarts the row and column counters.
// Output stream: one result per interior pixel (magnitude, gx, gy); m_tlast
// marks the last interior result of the frame. Border pixels give no result.
// Configuration: cfg_we writes image_width (index 0) or image_height (index 1);
// write only while the block is idle.
// Sequence: a taken pixel passes states GRAD, SQX, SQY, SQRT and DONE, then
// its result is loaded into the output register that drives m_tvalid; a pixel
// giving no result returns to idle after GRAD. The pace is set by the
// eight-step root unit and the shared squarer, one pixel in flight at a time.
// The result sits in an output register, so the next pixel is taken while it
// waits; a pixel finishing while that register is still full holds until
// m_tready drains it.
// Reset: width 640, height 480, counters and window cleared, no result pending.
// Line stores are not cleared; unwritten entries only feed border positions.
`default_nettype none
`include "sobel_edge_magnitude_macros.svh"

module sobel_edge_magnitude
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [sobel_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [sobel_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [sobel_pkg::PIX_W-1:0]         s_tdata,   // grey level [7:0]
    input  wire logic                                s_tuser,   // frame_start
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // edge_magnitude [7:0], gradient_x [18:8], gradient_y [29:19], zero pad
    output logic [sobel_pkg::OUT_DATA_W-1:0]         m_tdata,
    output logic                                     m_tlast    // frame_end
);
    import sobel_pkg::*;

    sobel_cmd_t    cmd;
    sobel_status_t status;

    logic [PIX_W-1:0]         edge_magnitude;
    logic signed [GRAD_W-1:0] gradient_x;
    logic signed [GRAD_W-1:0] gradient_y;

    sobel_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    sobel_datapath u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .grey_pixel     (s_tdata),
        .frame_start    (s_tuser),
        .cmd            (cmd),
        .status         (status),
        .m_tready       (m_tready),
        .m_tvalid       (m_tvalid),
        .edge_magnitude (edge_magnitude),
        .gradient_x     (gradient_x),
        .gradient_y     (gradient_y),
        .frame_end      (m_tlast)
    );

    assign m_tdata = {{(OUT_DATA_W - PIX_W - 2 * GRAD_W){1'b0}},
                      gradient_y, gradient_x, edge_magnitude};

    `SOBEL_ASSERT_SAME(a_load_free, clk, rst_n, cmd.out_load, status.out_free, "result overwritten")
    `SOBEL_ASSERT_NEXT(a_accept_grad, clk, rst_n, cmd.accept, cmd.grad && !s_tready, "no gradient step")
    `SOBEL_ASSERT_NEXT(a_root_start, clk, rst_n, cmd.sq_y, cmd.sqrt_step, "root unit not started")

endmodule

`default_nettype wire

>>> dv/sobel_edge_magnitude_checker.sv
// Checker for the Sobel edge magnitude block: predicts each result from the pixel stream.
`timescale 1ns / 1ps

module sobel_edge_magnitude_checker
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [sobel_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sobel_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [sobel_pkg::PIX_W-1:0]         s_tdata,   // grey level [7:0]
    input  logic                                s_tuser,   // frame_start
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    // edge_magnitude [7:0], gradient_x [18:8], gradient_y [29:19], zero pad
    input  logic [sobel_pkg::OUT_DATA_W-1:0]    m_tdata,
    input  logic                                m_tlast,   // frame_end
    output int                                  mismatch_count,
    output int                                  pending_results,
    output int                                  results_seen
);

    import sobel_pkg::*;

    localparam int GX_LSB  = PIX_W;
    localparam int GY_LSB  = PIX_W + GRAD_W;
    localparam int PAD_LSB = PIX_W + 2 * GRAD_W;
    localparam int PAD_W   = OUT_DATA_W - PAD_LSB;

    typedef struct packed {
        logic [PIX_W-1:0]  magnitude;
        logic [GRAD_W-1:0] gradient_x;
        logic [GRAD_W-1:0] gradient_y;
        logic              frame_end;
    } edge_result_t;

    logic [PIX_W-1:0]    upper_line [MAX_WIDTH];
    logic [PIX_W-1:0]    middle_line [MAX_WIDTH];
    logic [PIX_W-1:0]    window_px [6];
    int                  col_pos;
    int                  row_pos;
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    edge_result_t        expected_edges [$];

    function automatic logic [PIX_W-1:0] edge_root(input int sum);
        int root;
        int trial;
        if (sum >= 65536)
        begin
            return 8'hFF;
        end
        root = 0;
        for (int b = PIX_W - 1; b >= 0; b--)
        begin
            trial = root | (1 << b);
            if (trial * trial <= sum)
            begin
                root = trial;
            end
        end
        return root[PIX_W-1:0];
    endfunction

    task automatic predict_pixel(input logic [PIX_W-1:0] pix, input logic start);
        int               w;
        int               h;
        int               c;
        int               r;
        int               lft;
        int               rgt;
        int               upr;
        int               lwr;
        int               gx;
        int               gy;
        logic [PIX_W-1:0] top_px;
        logic [PIX_W-1:0] mid_px;
        edge_result_t     res;
        w = width_reg;
        h = height_reg;
        if (w < 3)
        begin
            w = 3;
        end
        if (w > MAX_WIDTH)
        begin
            w = MAX_WIDTH;
        end
        if (h < 3)
        begin
            h = 3;
        end
        if (start)
        begin
            col_pos = 0;
            row_pos = 0;
        end
        c = col_pos;
        r = row_pos;
        top_px = upper_line[c];
        mid_px = middle_line[c];
        if (c >= 2 && c < w && r >= 2 && r < h)
        begin
            lft = window_px[0] + 2 * window_px[1] + window_px[2];
            rgt = top_px + 2 * mid_px + pix;
            upr = window_px[0] + 2 * window_px[3] + top_px;
            lwr = window_px[2] + 2 * window_px[5] + pix;
            gx = rgt - lft;
            gy = lwr - upr;
            res.magnitude  = edge_root(gx * gx + gy * gy);
            res.gradient_x = gx[GRAD_W-1:0];
            res.gradient_y = gy[GRAD_W-1:0];
            res.frame_end  = (r == h - 1) && (c == w - 1);
            expected_edges.push_back(res);
        end
        upper_line[c]  = mid_px;
        middle_line[c] = pix;
        window_px[0] = window_px[3];
        window_px[1] = window_px[4];
        window_px[2] = window_px[5];
        window_px[3] = top_px;
        window_px[4] = mid_px;
        window_px[5] = pix;
        if (c + 1 >= w)
        begin
            col_pos = 0;
            if (row_pos < 65535)
            begin
                row_pos = row_pos + 1;
            end
        end
        else
        begin
            col_pos = c + 1;
        end
    endtask

    task automatic compare_field(input string field, input int expected_v, input int actual_v);
        if (expected_v != actual_v)
        begin
            mismatch_count++;
            $display("%0t: %s expected %0d actual %0d", $time, field, expected_v, actual_v);
        end
    endtask

    task automatic check_result();
        edge_result_t want;
        if (expected_edges.size() == 0)
        begin
            mismatch_count++;
            $display("%0t: unexpected result, expected none actual mag %0d gx %0d gy %0d last %0b",
                     $time, m_tdata[PIX_W-1:0], $signed(m_tdata[GX_LSB +: GRAD_W]),
                     $signed(m_tdata[GY_LSB +: GRAD_W]), m_tlast);
        end
        else
        begin
            want = expected_edges.pop_front();
            results_seen++;
            compare_field("edge_magnitude", want.magnitude, m_tdata[PIX_W-1:0]);
            compare_field("gradient_x", $signed(want.gradient_x),
                          $signed(m_tdata[GX_LSB +: GRAD_W]));
            compare_field("gradient_y", $signed(want.gradient_y),
                          $signed(m_tdata[GY_LSB +: GRAD_W]));
            compare_field("frame_end", want.frame_end, m_tlast);
            compare_field("tdata pad", 0, m_tdata[PAD_LSB +: PAD_W]);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            col_pos    = 0;
            row_pos    = 0;
            foreach (window_px[i])
            begin
                window_px[i] = '0;
            end
            expected_edges.delete();
            mismatch_count  = 0;
            results_seen    = 0;
            pending_results = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                check_result();
            end
            if (s_tvalid && s_tready)
            begin
                predict_pixel(s_tdata, s_tuser);
            end
            if (cfg_we)
            begin
                if (cfg_index == CFG_IDX_WIDTH)
                begin
                    width_reg = cfg_data[WIDTH_W-1:0];
                end
                else if (cfg_index == CFG_IDX_HEIGHT)
                begin
                    height_reg = cfg_data[HEIGHT_W-1:0];
                end
            end
            pending_results = expected_edges.size();
        end
    end

endmodule

>>> dv/sobel_edge_magnitude_tb.sv
// Testbench top for the Sobel edge magnitude block: stimulus, back-pressure and verdict.
`timescale 1ns / 1ps

module sobel_edge_magnitude_tb;

    import sobel_pkg::*;

    localparam int IDLE_PCT         = 17;
    localparam int DRAIN_CYCLES     = 20;
    localparam int SINK_HOLD_CYCLES = 300;
    localparam int RANDOM_ITEMS     = 200;
    localparam int END_WAIT_CYCLES  = 5000;

    typedef enum {PIX_UNIFORM, PIX_EXTREME, PIX_SMOOTH} pixel_style_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [PIX_W-1:0]      s_tdata;    // grey level [7:0]
    logic                  s_tuser;    // frame_start
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;    // edge_magnitude, gradient_x, gradient_y, zero pad
    logic                  m_tlast;    // frame_end

    int           mismatch_count;
    int           pending_results;
    int           results_seen;
    int           pixels_sent;
    int           random_sent;
    int           setups_run;
    bit           src_idle_on;
    bit           sink_idle_on;
    bit           sink_pause_req;
    pixel_style_t pixel_style;
    int           last_pixel;

    sobel_edge_magnitude i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    sobel_edge_magnitude_checker i_checker
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tlast         (m_tlast),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results),
        .results_seen    (results_seen)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #10_000_000;
        $display("sobel_edge_magnitude_tb: errors");
        $finish;
    end

    // Hold off the output on request, otherwise stall at random when sink idling is on.
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (sink_pause_req)
            begin
                sink_pause_req = 1'b0;
                m_tready <= 1'b0;
                repeat (SINK_HOLD_CYCLES) @(posedge clk);
            end
            m_tready <= !(sink_idle_on && $urandom_range(0, 99) < IDLE_PCT);
        end
    end

    function automatic logic [PIX_W-1:0] next_pixel();
        int v;
        case (pixel_style)
            PIX_EXTREME: v = $urandom_range(0, 1) ? 255 : 0;
            PIX_SMOOTH:
            begin
                v = last_pixel + int'($urandom_range(0, 16)) - 8;
                if (v < 0)
                begin
                    v = 0;
                end
                if (v > 255)
                begin
                    v = 255;
                end
            end
            default: v = $urandom_range(0, 255);
        endcase
        last_pixel = v;
        return v[PIX_W-1:0];
    endfunction

    task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic start);
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        s_tuser  <= start;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        pixels_sent++;
        if (src_idle_on)
        begin
            while ($urandom_range(0, 99) < IDLE_PCT)
            begin
                s_tvalid <= 1'b0;
                s_tdata  <= PIX_W'($urandom);
                @(posedge clk);
            end
        end
    endtask

    task automatic send_pixels(input int count, input logic first_start, input int restart_pct);
        logic start;
        for (int i = 0; i < count; i++)
        begin
            start = (i == 0) ? first_start : ($urandom_range(0, 99) < restart_pct);
            send_pixel(next_pixel(), start);
        end
    endtask

    task automatic set_frame_size(input logic [CFG_DATA_W-1:0] width_data,
                                  input logic [CFG_DATA_W-1:0] height_data);
        setups_run++;
        cfg_we    <= 1'b1;
        cfg_index <= CFG_IDX_WIDTH;
        cfg_data  <= width_data;
        @(posedge clk);
        cfg_index <= CFG_IDX_HEIGHT;
        cfg_data  <= height_data;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic random_phase();
        int k;
        int w_data;
        int h_data;
        int w_eff;
        int h_eff;
        int rows;
        int count;
        k = $urandom_range(0, 99);
        if (k < 60)
        begin
            w_data = $urandom_range(3, 10);
        end
        else if (k < 72)
        begin
            w_data = $urandom_range(0, 2);
        end
        else if (k < 85)
        begin
            w_data = $urandom_range(11, 40);
        end
        else
        begin
            w_data = ($urandom_range(1, 31) << WIDTH_W) | $urandom_range(3, 8);
        end
        w_eff = w_data & ((1 << WIDTH_W) - 1);
        if (w_eff < 3)
        begin
            w_eff = 3;
        end
        k = $urandom_range(0, 99);
        if (k < 55)
        begin
            h_data = $urandom_range(3, 6);
        end
        else if (k < 70)
        begin
            h_data = $urandom_range(0, 2);
        end
        else if (k < 85)
        begin
            h_data = $urandom_range(7, 12);
        end
        else
        begin
            h_data = $urandom_range(13, 65535);
        end
        h_eff = (h_data < 3) ? 3 : h_data;
        set_frame_size(w_data[CFG_DATA_W-1:0], h_data[CFG_DATA_W-1:0]);
        pixel_style = pixel_style_t'($urandom_range(0, 2));
        if (setups_run % 5 == 2)
        begin
            sink_pause_req = 1'b1;
        end
        if ($urandom_range(0, 99) < 85)
        begin
            repeat ($urandom_range(1, 2))
            begin
                rows = h_eff;
                if (rows * w_eff > 160)
                begin
                    rows = (160 / w_eff < 3) ? 3 : 160 / w_eff;
                end
                count = rows * w_eff + $urandom_range(0, w_eff);
                send_pixels(count, 1'b1, 0);
                random_sent += count;
            end
        end
        else
        begin
            count = $urandom_range(1, 3 * w_eff);
            send_pixels(count, 1'b1, 10);
            random_sent += count;
        end
        wait_idle();
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_IDX_WIDTH;
        cfg_data       = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = 1'b0;
        pixels_sent    = 0;
        random_sent    = 0;
        setups_run     = 0;
        src_idle_on    = 1'b1;
        sink_idle_on   = 1'b1;
        sink_pause_req = 1'b0;
        pixel_style    = PIX_UNIFORM;
        last_pixel     = 128;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Run at reset geometry, starting without a frame mark.
        send_pixels(20, 1'b0, 0);
        wait_idle();

        // Full-scale step in x, overrun past the last row, then a restart mid-row and a full-scale step in y.
        set_frame_size(16'd3, 16'd0);
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                send_pixel((c == 2) ? 8'hFF : 8'h00, (r == 0) && (c == 0));
            end
        end
        send_pixel(8'hA5, 1'b0);
        send_pixel(8'h5A, 1'b0);
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                send_pixel((r == 0) ? 8'hFF : 8'h00, (r == 0) && (c == 0));
            end
        end
        wait_idle();

        // Shrink the width in the middle of a row.
        set_frame_size(16'd6, 16'hFFFF);
        send_pixels(15, 1'b1, 0);
        wait_idle();
        set_frame_size(16'd2, 16'd5);
        send_pixels(4, 1'b0, 0);
        wait_idle();

        // Small frame with a long output stall.
        set_frame_size(16'd8, 16'd6);
        pixel_style    = PIX_SMOOTH;
        sink_pause_req = 1'b1;
        send_pixels(8 * 6 + 8, 1'b1, 0);
        wait_idle();

        // Clamped width, tallest height, then a full frame, no idling on either side.
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        pixel_style  = PIX_UNIFORM;
        set_frame_size(16'hFFFF, 16'hFFFF);
        send_pixels(30, 1'b1, 0);
        wait_idle();
        set_frame_size(16'd5, 16'd12);
        send_pixels(5 * 12, 1'b1, 0);
        wait_idle();
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;

        while (random_sent < RANDOM_ITEMS)
        begin
            random_phase();
        end

        s_tvalid <= 1'b0;
        for (int n = 0; n < END_WAIT_CYCLES && pending_results != 0; n++)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_results != 0)
        begin
            $display("%0t: %0d results expected but never delivered", $time, pending_results);
        end

        $display("summary: %0d pixels over %0d frame setups, %0d results checked",
                 pixels_sent, setups_run, results_seen);
        $display("summary: small to clamped widths, restarts, mid-row shrink, stalls both sides");
        if (mismatch_count == 0 && pending_results == 0)
        begin
            $display("sobel_edge_magnitude_tb: clean");
        end
        else
        begin
            $display("sobel_edge_magnitude_tb: errors");
        end
        $finish;
    end

endmodule
